/* rtl/core/i2c_master_bit_engine_macros.svh */
// Assertion helpers shared by the RTL of the I2C bit engine.
`ifndef I2C_MASTER_BIT_ENGINE_MACROS_SVH
`define I2C_MASTER_BIT_ENGINE_MACROS_SVH

// Same-cycle implication, disabled while reset is asserted.
`define I2CBE_ASSERT_IMPLY(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, disabled while reset is asserted.
`define I2CBE_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error(msg);

`endif

/* rtl/core/i2cbe_pkg.sv */
`default_nettype none

package i2cbe_pkg;

    // Action codes carried by an input transaction.
    localparam logic [2:0] ACT_TICK    = 3'd0;
    localparam logic [2:0] ACT_START   = 3'd1;
    localparam logic [2:0] ACT_STOP    = 3'd2;
    localparam logic [2:0] ACT_WRITE   = 3'd3;
    localparam logic [2:0] ACT_READ    = 3'd4;
    localparam logic [2:0] ACT_RESTART = 3'd5;

    localparam int unsigned BYTE_BITS = 8;

    // Running command, one-hot.
    typedef enum logic [5:0] {
        CMD_IDLE    = 6'b000001,
        CMD_START   = 6'b000010,
        CMD_STOP    = 6'b000100,
        CMD_WRITE   = 6'b001000,
        CMD_READ    = 6'b010000,
        CMD_RESTART = 6'b100000
    } t_cmd;

    typedef struct packed {
        t_cmd        cmd;
        logic [1:0]  phase;
        logic [3:0]  bit_index;
        logic [7:0]  shift_byte;
        logic        scl;
        logic        sda;
        logic        drv;
        logic        ack;
        logic [7:0]  last_read;
    } t_state;

    typedef struct packed {
        logic        scl;
        logic        sda_out;
        logic        sda_drive;
        logic        busy_res;
        logic        done_res;
        logic        ack_bit;
        logic [7:0]  read_value;
    } t_result;

    function automatic t_cmd act_to_cmd(input logic [2:0] act);
        t_cmd c;
        c = CMD_IDLE;
        unique case (act)
            ACT_START:   c = CMD_START;
            ACT_STOP:    c = CMD_STOP;
            ACT_WRITE:   c = CMD_WRITE;
            ACT_READ:    c = CMD_READ;
            ACT_RESTART: c = CMD_RESTART;
            default:     c = CMD_IDLE;
        endcase
        return c;
    endfunction

endpackage

`default_nettype wire

/* rtl/core/i2cbe_if.sv */
`default_nettype none

interface i2cbe_in_if;
    logic        valid;
    logic        ready;
    logic [2:0]  action;
    logic [7:0]  data;
    logic        sda_in;

    modport source (output valid, output action, output data, output sda_in, input ready);
    modport sink   (input valid, input action, input data, input sda_in, output ready);
endinterface

interface i2cbe_out_if;
    logic        valid;
    logic        ready;
    logic        scl;
    logic        sda_out;
    logic        sda_drive;
    logic        busy_res;
    logic        done_res;
    logic        ack_bit;
    logic [7:0]  read_value;

    modport source (output valid, output scl, output sda_out, output sda_drive,
                    output busy_res, output done_res, output ack_bit, output read_value,
                    input ready);
    modport sink   (input valid, input scl, input sda_out, input sda_drive,
                    input busy_res, input done_res, input ack_bit, input read_value,
                    output ready);
endinterface

`default_nettype wire

/* rtl/core/i2cbe_step.sv */
`default_nettype none

// Next-state logic: one bus action per tick, command latch while idle.
module i2cbe_step import i2cbe_pkg::*; (
    input  t_state      i_state,
    input  logic [2:0]  i_action,
    input  logic [7:0]  i_data,
    input  logic        i_sda_in,
    output t_state      o_state,
    output logic        o_done
);

    logic fin;

    always_comb begin
        o_state = i_state;
        fin     = 1'b0;
        if (i_action == ACT_TICK) begin
            unique case (i_state.cmd)
                CMD_IDLE: begin
                end
                CMD_START: begin
                    if (i_state.phase == 2'd0) begin
                        o_state.drv = 1'b1;
                        o_state.sda = 1'b0;
                        o_state.phase = 2'd1;
                    end else begin
                        o_state.scl = 1'b0;
                        fin = 1'b1;
                    end
                end
                CMD_STOP: begin
                    if (i_state.phase == 2'd0) begin
                        o_state.drv = 1'b1;
                        o_state.sda = 1'b0;
                        o_state.phase = 2'd1;
                    end else if (i_state.phase == 2'd1) begin
                        o_state.scl = 1'b1;
                        o_state.phase = 2'd2;
                    end else begin
                        o_state.sda = 1'b1;
                        fin = 1'b1;
                    end
                end
                CMD_RESTART: begin
                    if (i_state.phase == 2'd0) begin
                        o_state.drv = 1'b1;
                        o_state.sda = 1'b1;
                        o_state.phase = 2'd1;
                    end else if (i_state.phase == 2'd1) begin
                        o_state.scl = 1'b1;
                        o_state.phase = 2'd2;
                    end else if (i_state.phase == 2'd2) begin
                        o_state.sda = 1'b0;
                        o_state.phase = 2'd3;
                    end else begin
                        o_state.scl = 1'b0;
                        fin = 1'b1;
                    end
                end
                CMD_WRITE: begin
                    if (!i_state.bit_index[3]) begin
                        if (i_state.phase == 2'd0) begin
                            o_state.drv = 1'b1;
                            o_state.sda = i_state.shift_byte[BYTE_BITS-1];
                            o_state.phase = 2'd1;
                        end else if (i_state.phase == 2'd1) begin
                            o_state.scl = 1'b1;
                            o_state.phase = 2'd2;
                        end else begin
                            o_state.scl = 1'b0;
                            o_state.shift_byte = {i_state.shift_byte[6:0], 1'b0};
                            o_state.bit_index = i_state.bit_index + 4'd1;
                            o_state.phase = 2'd0;
                        end
                    end else if (i_state.phase == 2'd0) begin
                        o_state.drv = 1'b0;
                        o_state.phase = 2'd1;
                    end else if (i_state.phase == 2'd1) begin
                        o_state.scl = 1'b1;
                        o_state.phase = 2'd2;
                    end else if (i_state.phase == 2'd2) begin
                        o_state.ack = i_sda_in;
                        o_state.scl = 1'b0;
                        o_state.phase = 2'd3;
                    end else begin
                        o_state.drv = 1'b1;
                        fin = 1'b1;
                    end
                end
                CMD_READ: begin
                    if (!i_state.bit_index[3]) begin
                        if (i_state.phase == 2'd0) begin
                            o_state.drv = 1'b0;
                            o_state.phase = 2'd1;
                        end else if (i_state.phase == 2'd1) begin
                            o_state.scl = 1'b1;
                            o_state.phase = 2'd2;
                        end else begin
                            o_state.shift_byte = {i_state.shift_byte[6:0], i_sda_in};
                            o_state.scl = 1'b0;
                            o_state.bit_index = i_state.bit_index + 4'd1;
                            // The last data bit hands over to the ACK slot at phase zero.
                            o_state.phase = (i_state.bit_index == 4'd7) ? 2'd0 : 2'd1;
                        end
                    end else if (i_state.phase == 2'd0) begin
                        o_state.drv = 1'b1;
                        o_state.sda = 1'b0;
                        o_state.phase = 2'd1;
                    end else if (i_state.phase == 2'd1) begin
                        o_state.scl = 1'b1;
                        o_state.phase = 2'd2;
                    end else begin
                        o_state.scl = 1'b0;
                        o_state.last_read = i_state.shift_byte;
                        fin = 1'b1;
                    end
                end
                default: begin
                    fin = 1'b1;
                end
            endcase
            if (fin) begin
                o_state.cmd = CMD_IDLE;
                o_state.phase = 2'd0;
                o_state.bit_index = 4'd0;
            end
        end else if (i_action <= ACT_RESTART && i_state.cmd == CMD_IDLE) begin
            o_state.cmd = act_to_cmd(i_action);
            o_state.phase = 2'd0;
            o_state.bit_index = 4'd0;
            o_state.shift_byte = (i_action == ACT_WRITE) ? i_data : 8'd0;
        end
        o_done = fin;
    end

endmodule

`default_nettype wire

/* rtl/core/i2c_master_bit_engine.sv */
// Channel   Dir  Modport  Payload
// i_in      in   sink     action[2:0], data[7:0], sda_in
// o_out     out  source   scl, sda_out, sda_drive, busy_res, done_res, ack_bit, read_value[7:0]
//
// Every input transaction yields exactly one output transaction.
// A result passes through the input register and then the result register; one transaction per
// cycle is sustained while the output is not stalled, with one next-state step between the two.
// i_rst_n is synchronous and active low; after it SDA is driven high and SCL is high.
// When the output is stalled, the result register holds and the input register fills;
// ready drops only when both are occupied.
`default_nettype none
`include "i2c_master_bit_engine_macros.svh"

module i2c_master_bit_engine import i2cbe_pkg::*; (
    input  logic        i_clk,
    input  logic        i_rst_n,
    i2cbe_in_if.sink    i_in,
    i2cbe_out_if.source o_out
);

    // Input register stage.
    logic        r_in_valid;
    logic [2:0]  r_in_action;
    logic [7:0]  r_in_data;
    logic        r_in_sda;

    // Bus state and result register.
    t_state      r_state;
    logic        r_out_valid;
    t_result     r_out;

    t_state      n_state;
    t_result     n_out;
    logic        step_done;
    logic        advance;
    logic        in_take;

    // The step fires whenever the input register is full and the result register can take a new value.
    assign advance = r_in_valid && (!r_out_valid || o_out.ready);
    assign i_in.ready = !r_in_valid || advance;
    assign in_take = i_in.valid && i_in.ready;

    i2cbe_step u_step (
        .i_state  (r_state),
        .i_action (r_in_action),
        .i_data   (r_in_data),
        .i_sda_in (r_in_sda),
        .o_state  (n_state),
        .o_done   (step_done)
    );

    // The result reflects the pin levels after this step. A released SDA reads as
    // the pulled-up level.
    always_comb begin
        n_out.scl        = n_state.scl;
        n_out.sda_out    = n_state.drv ? n_state.sda : 1'b1;
        n_out.sda_drive  = n_state.drv;
        n_out.busy_res   = (n_state.cmd != CMD_IDLE);
        n_out.done_res   = step_done;
        n_out.ack_bit    = n_state.ack;
        n_out.read_value = n_state.last_read;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (in_take) begin
            r_in_valid <= 1'b1;
        end else if (advance) begin
            r_in_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_take) begin
            r_in_action <= i_in.action;
            r_in_data   <= i_in.data;
            r_in_sda    <= i_in.sda_in;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state.cmd        <= CMD_IDLE;
            r_state.phase      <= 2'd0;
            r_state.bit_index  <= 4'd0;
            r_state.shift_byte <= 8'd0;
            r_state.scl        <= 1'b1;
            r_state.sda        <= 1'b1;
            r_state.drv        <= 1'b1;
            r_state.ack        <= 1'b0;
            r_state.last_read  <= 8'd0;
        end else if (advance) begin
            r_state <= n_state;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (advance) begin
            r_out_valid <= 1'b1;
        end else if (o_out.ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (advance) begin
            r_out <= n_out;
        end
    end

    assign o_out.valid      = r_out_valid;
    assign o_out.scl        = r_out.scl;
    assign o_out.sda_out    = r_out.sda_out;
    assign o_out.sda_drive  = r_out.sda_drive;
    assign o_out.busy_res   = r_out.busy_res;
    assign o_out.done_res   = r_out.done_res;
    assign o_out.ack_bit    = r_out.ack_bit;
    assign o_out.read_value = r_out.read_value;

    // A finishing step always leaves the engine idle.
    `I2CBE_ASSERT_IMPLY(a_done_not_busy, i_clk, i_rst_n, r_out_valid && r_out.done_res, !r_out.busy_res, "done reported while still busy")
    // Idle means the sequencer counters are back at zero.
    `I2CBE_ASSERT_IMPLY(a_idle_clean, i_clk, i_rst_n, r_state.cmd == CMD_IDLE, r_state.phase == 2'd0 && r_state.bit_index == 4'd0, "idle with stale sequencer counters")
    // The bit counter never passes the ACK slot.
    `I2CBE_ASSERT_IMPLY(a_bit_range, i_clk, i_rst_n, r_state.bit_index[3], r_state.bit_index[2:0] == 3'd0, "bit index beyond eight")
    // SDA is released only inside a byte transfer.
    `I2CBE_ASSERT_IMPLY(a_release_in_byte, i_clk, i_rst_n, !r_state.drv, r_state.cmd == CMD_WRITE || r_state.cmd == CMD_READ, "SDA released outside a byte transfer")
    // Without a step the bus state must not move.
    `I2CBE_ASSERT_NEXT(a_hold_state, i_clk, i_rst_n, !advance, $stable(r_state), "bus state changed without a step")

endmodule

`default_nettype wire
